### rtl/core/tdds_pkg.sv
package tdds_pkg;

    localparam int unsigned TABLE_ENTRIES = 1024;
    localparam int unsigned INDEX_SHIFT   = 16;
    localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int unsigned NUM_AXES      = 3;
    localparam int unsigned WORD_W        = 16;
    localparam int unsigned ACC_W         = 32;
    localparam int unsigned AMP_W         = 16;
    localparam int unsigned OFFSET_W      = 10;
    localparam int unsigned MASK_W        = 3;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIBRATE_AXIS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE_CODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TUNING_WORD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_ENABLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET_Y = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET_Z = 3'd7;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        MODE_STOP        = 2'd0,
        MODE_SINGLE_AXIS = 2'd1,
        MODE_MULTI_AXIS  = 2'd2
    } t_mode;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [WORD_W-1:0] t_word;
    typedef t_idx  [NUM_AXES-1:0] t_idx_vec;
    typedef t_word [NUM_AXES-1:0] t_word_vec;
    typedef logic [TABLE_ENTRIES-1:0][WORD_W-1:0] t_rom;

    typedef struct packed {
        t_mode                     mode;
        logic [1:0]                vibrate_axis;
        logic [ACC_W-1:0]          tuning_word;
        logic [MASK_W-1:0]         axis_mask;
        logic [OFFSET_W-1:0]       offset_x;
        logic [OFFSET_W-1:0]       offset_y;
        logic [OFFSET_W-1:0]       offset_z;
    } t_phase_cfg;

    typedef struct packed {
        logic                valid;
        logic [NUM_AXES-1:0] lane_en;
        t_idx_vec            addr;
    } t_addr_stage;

    localparam longint          Q30_ONE     = 64'sd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // sin(pi/2 * r / TABLE_ENTRIES) in q30, taylor series to the x^15 term
    function automatic longint quarter_sine_q30(input longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = (HALF_PI_Q30 * r) / TABLE_ENTRIES;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 210;
        sum  = sum - longint'(term);
        if (sum > Q30_ONE) begin
            sum = Q30_ONE;
        end
        if (sum < 0) begin
            sum = 0;
        end
        return sum;
    endfunction

    // offset sine table, round((sin + 1) / 2 * 65535) half up
    function automatic t_rom build_sine_rom();
        t_rom            rom;
        longint unsigned t;
        longint unsigned q;
        longint unsigned rem;
        longint          s;
        longint unsigned num;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            t   = 64'(4 * i);
            q   = t / TABLE_ENTRIES;
            rem = t - q * TABLE_ENTRIES;
            case (q)
                64'd0:   s = quarter_sine_q30(rem);
                64'd1:   s = quarter_sine_q30(TABLE_ENTRIES - rem);
                64'd2:   s = -quarter_sine_q30(rem);
                default: s = -quarter_sine_q30(TABLE_ENTRIES - rem);
            endcase
            num    = longint'(s + Q30_ONE) * 64'd65535;
            rom[i] = WORD_W'((num + (64'd1 << 30)) >> 31);
        end
        return rom;
    endfunction

endpackage

### rtl/core/three_axis_dds_sine_driver.sv
// o_valid rises after the accepting edge, through the address, rom read and scale registers
// throughput: one transaction per cycle while i_stall is low; each stage holds one item
// and bubbles collapse under output stall, so input is taken while a finished result waits
// stopped mode advances the accumulator and produces no output transaction
// reset (synchronous, active low) clears the accumulator, the pipeline valids and
// loads the configuration reset values; the sine rom is constant and needs no clearing
module three_axis_dds_sine_driver (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_restart_phase,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [tdds_pkg::WORD_W-1:0]      o_drive_x,
    output logic [tdds_pkg::WORD_W-1:0]      o_drive_y,
    output logic [tdds_pkg::WORD_W-1:0]      o_drive_z,
    output logic [tdds_pkg::WORD_W-1:0]      o_drive_w,
    input  logic                             i_cfg_we,
    input  logic [tdds_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tdds_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tdds_pkg::*;

    t_mode               r_mode;
    logic [1:0]          r_vibrate_axis;
    logic [AMP_W-1:0]    r_amplitude;
    logic [ACC_W-1:0]    r_tuning_word;
    logic [MASK_W-1:0]   r_axis_mask;
    logic [OFFSET_W-1:0] r_offset_x;
    logic [OFFSET_W-1:0] r_offset_y;
    logic [OFFSET_W-1:0] r_offset_z;

    t_phase_cfg          phase_cfg;
    t_addr_stage         addr_stage;
    logic                r_v1;
    logic [NUM_AXES-1:0] r_lane_en1;
    logic                r_v2;
    t_word_vec           rom_word;
    t_word_vec           drive;

    logic adv2;
    logic adv1;
    logic adv0;
    logic accept;

    // each stage moves when the one after it is empty or moving
    assign adv2   = !r_v2 || !i_stall;
    assign adv1   = !r_v1 || adv2;
    assign adv0   = !addr_stage.valid || adv1;
    assign accept = i_valid && adv0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_STOP;
            r_vibrate_axis <= AXIS_X;
            r_amplitude    <= '0;
            r_tuning_word  <= '0;
            r_axis_mask    <= 3'b011;
            r_offset_x     <= '0;
            r_offset_y     <= OFFSET_W'(256);
            r_offset_z     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OUTPUT_MODE:    r_mode         <= t_mode'(i_cfg_data[1:0]);
                CFG_VIBRATE_AXIS:   r_vibrate_axis <= i_cfg_data[1:0];
                CFG_AMPLITUDE_CODE: r_amplitude    <= i_cfg_data[AMP_W-1:0];
                CFG_TUNING_WORD:    r_tuning_word  <= i_cfg_data[ACC_W-1:0];
                CFG_AXIS_ENABLE:    r_axis_mask    <= i_cfg_data[MASK_W-1:0];
                CFG_PHASE_OFFSET_X: r_offset_x     <= i_cfg_data[OFFSET_W-1:0];
                CFG_PHASE_OFFSET_Y: r_offset_y     <= i_cfg_data[OFFSET_W-1:0];
                CFG_PHASE_OFFSET_Z: r_offset_z     <= i_cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    assign phase_cfg.mode         = r_mode;
    assign phase_cfg.vibrate_axis = r_vibrate_axis;
    assign phase_cfg.tuning_word  = r_tuning_word;
    assign phase_cfg.axis_mask    = r_axis_mask;
    assign phase_cfg.offset_x     = r_offset_x;
    assign phase_cfg.offset_y     = r_offset_y;
    assign phase_cfg.offset_z     = r_offset_z;

    tdds_phase u_phase (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (adv0),
        .i_accept  (accept),
        .i_restart (i_restart_phase),
        .i_cfg     (phase_cfg),
        .o_stage   (addr_stage)
    );

    for (genvar k = 0; k < NUM_AXES; k++) begin : g_rom
        tdds_rom u_rom (
            .i_clk  (i_clk),
            .i_en   (adv1),
            .i_addr (addr_stage.addr[k]),
            .o_data (rom_word[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= addr_stage.valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_lane_en1 <= addr_stage.lane_en;
        end
    end

    tdds_scale u_scale (
        .i_clk       (i_clk),
        .i_load      (adv2),
        .i_word      (rom_word),
        .i_lane_en   (r_lane_en1),
        .i_amplitude (r_amplitude),
        .o_drive     (drive)
    );

    assign o_stall   = !adv0;
    assign o_valid   = r_v2;
    assign o_drive_x = drive[0];
    assign o_drive_y = drive[1];
    assign o_drive_z = drive[2];
    assign o_drive_w = '0;

endmodule

### rtl/core/tdds_phase.sv
module tdds_phase (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic                 i_accept,
    input  logic                 i_restart,
    input  tdds_pkg::t_phase_cfg i_cfg,
    output tdds_pkg::t_addr_stage o_stage
);
    import tdds_pkg::*;

    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    n_acc;
    logic                r_valid;
    logic                n_emit;
    logic [NUM_AXES-1:0] r_lane_en;
    logic [NUM_AXES-1:0] n_lane_en;
    t_idx_vec            r_addr;
    t_idx_vec            n_addr;
    t_idx                base;

    // restart clears the accumulator ahead of this transaction's increment
    assign n_acc = (i_restart ? '0 : r_acc) + i_cfg.tuning_word;
    assign base  = n_acc[INDEX_SHIFT +: IDX_W];

    always_comb begin
        n_emit    = 1'b0;
        n_lane_en = '0;
        n_addr    = {NUM_AXES{base}};
        unique case (i_cfg.mode)
            MODE_SINGLE_AXIS: begin
                n_emit = 1'b1;
                unique case (i_cfg.vibrate_axis)
                    AXIS_X:  n_lane_en = 3'b001;
                    AXIS_Y:  n_lane_en = 3'b010;
                    AXIS_Z:  n_lane_en = 3'b100;
                    default: n_lane_en = 3'b000;
                endcase
            end
            MODE_MULTI_AXIS: begin
                n_emit    = 1'b1;
                n_lane_en = i_cfg.axis_mask;
                n_addr[0] = base + IDX_W'(i_cfg.offset_x);
                n_addr[1] = base + IDX_W'(i_cfg.offset_y);
                n_addr[2] = base + IDX_W'(i_cfg.offset_z);
            end
            MODE_STOP: begin
                n_emit = 1'b0;
            end
            default: begin
                n_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_acc <= n_acc;
            end
            if (i_load) begin
                r_valid <= i_accept && n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lane_en <= n_lane_en;
            r_addr    <= n_addr;
        end
    end

    assign o_stage.valid   = r_valid;
    assign o_stage.lane_en = r_lane_en;
    assign o_stage.addr    = r_addr;

endmodule

### rtl/core/tdds_rom.sv
module tdds_rom (
    input  logic           i_clk,
    input  logic           i_en,
    input  tdds_pkg::t_idx i_addr,
    output tdds_pkg::t_word o_data
);
    import tdds_pkg::*;

    localparam t_rom SINE_ROM = build_sine_rom();

    t_word r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= SINE_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

### rtl/core/tdds_scale.sv
module tdds_scale (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  tdds_pkg::t_word_vec               i_word,
    input  logic [tdds_pkg::NUM_AXES-1:0]     i_lane_en,
    input  logic [tdds_pkg::AMP_W-1:0]        i_amplitude,
    output tdds_pkg::t_word_vec               o_drive
);
    import tdds_pkg::*;

    t_word_vec r_drive;
    t_word_vec n_drive;
    logic [WORD_W+AMP_W-1:0] prod [NUM_AXES];

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            prod[k]    = (WORD_W+AMP_W)'(i_word[k]) * (WORD_W+AMP_W)'(i_amplitude);
            n_drive[k] = i_lane_en[k] ? prod[k][WORD_W+AMP_W-1 -: WORD_W] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive = r_drive;

endmodule

### rtl/core/tdds_checker.sv
module tdds_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [tdds_pkg::WORD_W-1:0] o_drive_x,
    input logic [tdds_pkg::WORD_W-1:0] o_drive_y,
    input logic [tdds_pkg::WORD_W-1:0] o_drive_z,
    input logic [tdds_pkg::WORD_W-1:0] o_drive_w
);
    import tdds_pkg::*;

    // fourth channel carries nothing
    a_w_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_drive_w == '0)
        else $error("fourth channel not zero");

    // reset empties the output stage
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_drive_x) && $stable(o_drive_y)
            && $stable(o_drive_z))
        else $error("stalled output transaction changed");

endmodule

bind three_axis_dds_sine_driver tdds_checker u_tdds_checker (.*);
